// File: rtl/dgc_pkg.sv
// Shared types and constants of the digit glyph coverage raster.
package dgc_pkg;

  // Squared distance and root widths (subpixel grid up to 254 x 510)
  localparam int SQ_W  = 20;
  localparam int RT_W  = SQ_W / 2;
  // Signed subpixel coordinate and offset width
  localparam int CRD_W = 11;
  localparam int RAD_W = 7;
  localparam int DST_W = RT_W + 1;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  localparam logic [5:0] COLON_W_RESET = 6'd20;

  // Coverage ramp limits in subpixels
  localparam logic [DST_W-1:0] FULL_DIGIT = DST_W'(4);
  localparam logic [DST_W-1:0] EDGE_DIGIT = DST_W'(8);
  localparam logic [DST_W-1:0] FULL_COLON = DST_W'(8);
  localparam logic [DST_W-1:0] EDGE_COLON = DST_W'(12);
  localparam logic [DST_W-1:0] DIST_FAR   = '1;
  localparam logic [7:0]       COV_MAX    = 8'd255;

  // Offset from a skeleton point to the pixel center
  typedef struct packed {
    logic signed [CRD_W-1:0] dx;
    logic signed [CRD_W-1:0] dy;
  } vec_t;

  // Per-request stroke selection that rides along with the distances
  typedef struct packed {
    logic             hit_seg;
    logic             hit_ring;
    logic             colon;
    logic [RAD_W-1:0] rad;
  } side_t;

endpackage

// File: rtl/dgc_geom.sv
// Geometry pipeline: subpixel position, segment projection, squared distances.
module dgc_geom import dgc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      code,
  input  logic [5:0]      pix_x,
  input  logic [6:0]      pix_y,
  input  logic [5:0]      colon_w,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [SQ_W-1:0] seg_sq,
  output logic [SQ_W-1:0] ring_sq,
  output side_t           side
);

  localparam int NS    = 6;
  localparam int NDIAG = 6;
  localparam int NVERT = 5;
  localparam int NHOR  = 4;
  localparam int NSEG  = NDIAG + NVERT + NHOR + 1;

  // Diagonal strokes: 1 short, 2 slant, 4 slant, 6 slant, 7 slant, 9 tail
  localparam int DAX [NDIAG] = '{56, 152, 120, 136, 152, 160};
  localparam int DAY [NDIAG] = '{72, 80, 24, 40, 24, 96};
  localparam int DBX [NDIAG] = '{88, 24, 24, 24, 56, 40};
  localparam int DBY [NDIAG] = '{24, 296, 200, 176, 296, 272};
  // Vertical strokes: 0 left, 0 right, 1 stem, 4 stem, 5 left
  localparam int VX  [NVERT] = '{16, 160, 88, 120, 32};
  localparam int VY0 [NVERT] = '{88, 88, 24, 24, 24};
  localparam int VY1 [NVERT] = '{232, 232, 296, 296, 136};
  // Horizontal strokes: 2 base, 4 bar, 5 top, 7 top
  localparam int HY  [NHOR]  = '{296, 200, 24, 24};
  localparam int HX0 [NHOR]  = '{24, 24, 32, 24};
  localparam int HX1 [NHOR]  = '{152, 152, 144, 152};

  localparam int I_S1B = 0;
  localparam int I_S2B = 1;
  localparam int I_S4A = 2;
  localparam int I_S6  = 3;
  localparam int I_S7B = 4;
  localparam int I_S9  = 5;
  localparam int I_S0A = NDIAG;
  localparam int I_S0B = NDIAG + 1;
  localparam int I_S1A = NDIAG + 2;
  localparam int I_S4C = NDIAG + 3;
  localparam int I_S5B = NDIAG + 4;
  localparam int I_S2C = NDIAG + NVERT;
  localparam int I_S4B = NDIAG + NVERT + 1;
  localparam int I_S5A = NDIAG + NVERT + 2;
  localparam int I_S7A = NDIAG + NVERT + 3;
  localparam int I_DOT = NSEG - 1;

  typedef enum logic [3:0] {
    CLS_D0, CLS_D1, CLS_D2, CLS_D3, CLS_D4, CLS_D5, CLS_D6, CLS_D7, CLS_D8, CLS_D9,
    CLS_COLON, CLS_NONE
  } cls_t;

  function automatic logic [SQ_W-1:0] sq(input vec_t v);
    logic signed [2*CRD_W-1:0] a;
    logic signed [2*CRD_W-1:0] b;
    a = v.dx * v.dx;
    b = v.dy * v.dy;
    return SQ_W'(a + b);
  endfunction

  function automatic logic [SQ_W-1:0] min2(input logic [SQ_W-1:0] a, input logic [SQ_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  // Stage handshake: a stage loads when empty or when the next one loads
  logic [NS:1] v_r;
  logic [NS:1] rdy;

  always_comb begin
    rdy[NS] = !v_r[NS] || !out_stall;
    for (int k = NS - 1; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[1];
  assign out_valid = v_r[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // Stage 1: classify the code and place the pixel center on the grid
  cls_t             cls1_nxt, cls1_r;
  logic [7:0]       x1_r;
  logic [8:0]       y1_r;
  logic [6:0]       cx1_r;

  always_comb begin
    if (code == CHAR_COLON) begin
      cls1_nxt = CLS_COLON;
    end else if (code >= CHAR_ZERO && code <= CHAR_NINE) begin
      cls1_nxt = cls_t'(4'(code - CHAR_ZERO));
    end else begin
      cls1_nxt = CLS_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      cls1_r <= cls1_nxt;
      x1_r   <= {pix_x, 2'b10};
      y1_r   <= {pix_y, 2'b10};
      cx1_r  <= {colon_w[5:1], 2'b00};
    end
  end

  // Stage 2: projection dot products, ring center and stroke selection
  logic signed [CRD_W-1:0] xs1, ys1, cxs1;
  logic signed [19:0]      t2_nxt [NDIAG];
  logic signed [19:0]      t2_r   [NDIAG];
  logic signed [CRD_W-1:0] rcx, rcy;
  side_t                   side2_nxt, side2_r;
  vec_t                    rv2_nxt, rv2_r, dv2_nxt, dv2_r;
  logic                    up2_r;
  cls_t                    cls2_r;
  logic signed [CRD_W-1:0] xs2_r, ys2_r;

  assign xs1  = signed'({3'b000, x1_r});
  assign ys1  = signed'({2'b00, y1_r});
  assign cxs1 = signed'({4'b0000, cx1_r});

  for (genvar k = 0; k < NDIAG; k++) begin : g_dot
    localparam logic signed [CRD_W-1:0] Ax = CRD_W'(DAX[k]);
    localparam logic signed [CRD_W-1:0] Ay = CRD_W'(DAY[k]);
    localparam logic signed [19:0]      Ux = 20'(DBX[k] - DAX[k]);
    localparam logic signed [19:0]      Uy = 20'(DBY[k] - DAY[k]);
    assign t2_nxt[k] = ((xs1 - Ax) * Ux) + ((ys1 - Ay) * Uy);
  end

  always_comb begin
    rcx       = '0;
    rcy       = '0;
    side2_nxt = '0;
    case (cls1_r)
      CLS_D0: begin
        if (ys1 <= 88) begin
          rcx = 11'sd88; rcy = 11'sd88; side2_nxt.rad = 7'd72; side2_nxt.hit_ring = 1'b1;
        end else if (ys1 >= 232) begin
          rcx = 11'sd88; rcy = 11'sd232; side2_nxt.rad = 7'd72; side2_nxt.hit_ring = 1'b1;
        end else begin
          side2_nxt.hit_seg = 1'b1;
        end
      end
      CLS_D1: side2_nxt.hit_seg = 1'b1;
      CLS_D2: begin
        side2_nxt.hit_seg = 1'b1;
        if (ys1 <= 80) begin
          rcx = 11'sd88; rcy = 11'sd80; side2_nxt.rad = 7'd64; side2_nxt.hit_ring = 1'b1;
        end
      end
      CLS_D3: begin
        side2_nxt.hit_ring = 1'b1;
        if (ys1 <= 160) begin
          rcx = 11'sd88; rcy = 11'sd88; side2_nxt.rad = 7'd64;
        end else begin
          rcx = 11'sd88; rcy = 11'sd232; side2_nxt.rad = 7'd72;
        end
      end
      CLS_D4: side2_nxt.hit_seg = 1'b1;
      CLS_D5: begin
        side2_nxt.hit_seg = 1'b1; side2_nxt.hit_ring = 1'b1;
        rcx = 11'sd80; rcy = 11'sd216; side2_nxt.rad = 7'd80;
      end
      CLS_D6: begin
        side2_nxt.hit_seg = 1'b1; side2_nxt.hit_ring = 1'b1;
        rcx = 11'sd88; rcy = 11'sd224; side2_nxt.rad = 7'd72;
      end
      CLS_D7: side2_nxt.hit_seg = 1'b1;
      CLS_D8: begin
        side2_nxt.hit_ring = 1'b1;
        if (ys1 <= 160) begin
          rcx = 11'sd88; rcy = 11'sd96; side2_nxt.rad = 7'd64;
        end else begin
          rcx = 11'sd88; rcy = 11'sd224; side2_nxt.rad = 7'd72;
        end
      end
      CLS_D9: begin
        if (ys1 <= 180) begin
          rcx = 11'sd88; rcy = 11'sd96; side2_nxt.rad = 7'd72; side2_nxt.hit_ring = 1'b1;
        end else begin
          side2_nxt.hit_seg = 1'b1;
        end
      end
      CLS_COLON: begin
        // upper dot on the ring path, lower dot on the segment path
        side2_nxt.hit_seg = 1'b1; side2_nxt.hit_ring = 1'b1; side2_nxt.colon = 1'b1;
        rcx = cxs1; rcy = 11'sd112;
      end
      default: side2_nxt = '0;
    endcase
  end

  assign rv2_nxt.dx = xs1 - rcx;
  assign rv2_nxt.dy = ys1 - rcy;
  assign dv2_nxt.dx = xs1 - cxs1;
  assign dv2_nxt.dy = ys1 - 11'sd208;

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      t2_r    <= t2_nxt;
      side2_r <= side2_nxt;
      rv2_r   <= rv2_nxt;
      dv2_r   <= dv2_nxt;
      up2_r   <= (ys1 <= 80);
      cls2_r  <= cls1_r;
      xs2_r   <= xs1;
      ys2_r   <= ys1;
    end
  end

  // Stage 3: scale the dot products by the stroke direction, flag clamping
  logic signed [27:0]      tu3_nxt [NDIAG];
  logic signed [27:0]      tv3_nxt [NDIAG];
  logic signed [27:0]      tu3_r   [NDIAG];
  logic signed [27:0]      tv3_r   [NDIAG];
  logic [NDIAG-1:0]        lo3_nxt, hi3_nxt, lo3_r, hi3_r;
  side_t                   side3_r;
  vec_t                    rv3_r, dv3_r;
  logic                    up3_r;
  cls_t                    cls3_r;
  logic signed [CRD_W-1:0] xs3_r, ys3_r;

  for (genvar k = 0; k < NDIAG; k++) begin : g_scale
    localparam int                 UxI  = DBX[k] - DAX[k];
    localparam int                 UyI  = DBY[k] - DAY[k];
    localparam logic signed [27:0] UxW  = 28'(UxI);
    localparam logic signed [27:0] UyW  = 28'(UyI);
    localparam logic signed [27:0] Len2 = 28'(UxI * UxI + UyI * UyI);
    assign tu3_nxt[k] = t2_r[k] * UxW;
    assign tv3_nxt[k] = t2_r[k] * UyW;
    assign lo3_nxt[k] = (t2_r[k] <= 20'sd0);
    assign hi3_nxt[k] = (t2_r[k] >= Len2);
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      tu3_r   <= tu3_nxt;
      tv3_r   <= tv3_nxt;
      lo3_r   <= lo3_nxt;
      hi3_r   <= hi3_nxt;
      side3_r <= side2_r;
      rv3_r   <= rv2_r;
      dv3_r   <= dv2_r;
      up3_r   <= up2_r;
      cls3_r  <= cls2_r;
      xs3_r   <= xs2_r;
      ys3_r   <= ys2_r;
    end
  end

  // Stage 4: nearest skeleton point of every stroke, offset to the pixel
  vec_t  segv4_nxt [NSEG];
  vec_t  segv4_r   [NSEG];
  vec_t  rv4_r;
  side_t side4_r;
  logic  up4_r;
  cls_t  cls4_r;

  for (genvar k = 0; k < NDIAG; k++) begin : g_proj
    localparam int                      UxI   = DBX[k] - DAX[k];
    localparam int                      UyI   = DBY[k] - DAY[k];
    localparam int                      Len2I = UxI * UxI + UyI * UyI;
    // Unclamped products stay below 2^25, so this reciprocal is exact there
    localparam int                      Sh    = 25 + $clog2(Len2I);
    localparam logic [25:0]             Rcp   =
      26'(((64'd1 << Sh) + 64'(Len2I) - 64'd1) / 64'(Len2I));
    localparam logic signed [CRD_W-1:0] Ax    = CRD_W'(DAX[k]);
    localparam logic signed [CRD_W-1:0] Ay    = CRD_W'(DAY[k]);
    localparam logic signed [CRD_W-1:0] Bx    = CRD_W'(DBX[k]);
    localparam logic signed [CRD_W-1:0] By    = CRD_W'(DBY[k]);
    logic [27:0]             ux_mag, uy_mag;
    logic [50:0]             px_prod, py_prod;
    logic signed [CRD_W-1:0] qx, qy;
    // truncating signed division by the squared length, rounds toward zero
    assign ux_mag  = tu3_r[k][27] ? 28'(-tu3_r[k]) : 28'(tu3_r[k]);
    assign uy_mag  = tv3_r[k][27] ? 28'(-tv3_r[k]) : 28'(tv3_r[k]);
    assign px_prod = 51'(ux_mag[24:0]) * 51'(Rcp);
    assign py_prod = 51'(uy_mag[24:0]) * 51'(Rcp);
    assign qx = tu3_r[k][27] ? -CRD_W'(px_prod >> Sh) : CRD_W'(px_prod >> Sh);
    assign qy = tv3_r[k][27] ? -CRD_W'(py_prod >> Sh) : CRD_W'(py_prod >> Sh);
    assign segv4_nxt[k].dx = lo3_r[k] ? (xs3_r - Ax) :
                             hi3_r[k] ? (xs3_r - Bx) : (xs3_r - Ax - qx);
    assign segv4_nxt[k].dy = lo3_r[k] ? (ys3_r - Ay) :
                             hi3_r[k] ? (ys3_r - By) : (ys3_r - Ay - qy);
  end

  for (genvar k = 0; k < NVERT; k++) begin : g_vert
    localparam logic signed [CRD_W-1:0] X0 = CRD_W'(VX[k]);
    localparam logic signed [CRD_W-1:0] Y0 = CRD_W'(VY0[k]);
    localparam logic signed [CRD_W-1:0] Y1 = CRD_W'(VY1[k]);
    assign segv4_nxt[NDIAG+k].dx = xs3_r - X0;
    assign segv4_nxt[NDIAG+k].dy = (ys3_r < Y0) ? (ys3_r - Y0) :
                                   (ys3_r > Y1) ? (ys3_r - Y1) : '0;
  end

  for (genvar k = 0; k < NHOR; k++) begin : g_hor
    localparam logic signed [CRD_W-1:0] Y0 = CRD_W'(HY[k]);
    localparam logic signed [CRD_W-1:0] X0 = CRD_W'(HX0[k]);
    localparam logic signed [CRD_W-1:0] X1 = CRD_W'(HX1[k]);
    assign segv4_nxt[NDIAG+NVERT+k].dy = ys3_r - Y0;
    assign segv4_nxt[NDIAG+NVERT+k].dx = (xs3_r < X0) ? (xs3_r - X0) :
                                         (xs3_r > X1) ? (xs3_r - X1) : '0;
  end

  assign segv4_nxt[I_DOT] = dv3_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      segv4_r <= segv4_nxt;
      rv4_r   <= rv3_r;
      side4_r <= side3_r;
      up4_r   <= up3_r;
      cls4_r  <= cls3_r;
    end
  end

  // Stage 5: square every offset
  logic [SQ_W-1:0] sq5_r [NSEG];
  logic [SQ_W-1:0] rsq5_r;
  side_t           side5_r;
  logic            up5_r;
  cls_t            cls5_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      for (int i = 0; i < NSEG; i++) begin
        sq5_r[i] <= sq(segv4_r[i]);
      end
      rsq5_r  <= sq(rv4_r);
      side5_r <= side4_r;
      up5_r   <= up4_r;
      cls5_r  <= cls4_r;
    end
  end

  // Stage 6: nearest stroke of the glyph
  logic [SQ_W-1:0] seg6_nxt, seg6_r, rsq6_r;
  side_t           side6_r;

  always_comb begin
    case (cls5_r)
      CLS_D0:    seg6_nxt = min2(sq5_r[I_S0A], sq5_r[I_S0B]);
      CLS_D1:    seg6_nxt = min2(sq5_r[I_S1A], sq5_r[I_S1B]);
      CLS_D2:    seg6_nxt = up5_r ? sq5_r[I_S2C] : min2(sq5_r[I_S2B], sq5_r[I_S2C]);
      CLS_D4:    seg6_nxt = min2(min2(sq5_r[I_S4A], sq5_r[I_S4B]), sq5_r[I_S4C]);
      CLS_D5:    seg6_nxt = min2(sq5_r[I_S5A], sq5_r[I_S5B]);
      CLS_D6:    seg6_nxt = sq5_r[I_S6];
      CLS_D7:    seg6_nxt = min2(sq5_r[I_S7A], sq5_r[I_S7B]);
      CLS_D9:    seg6_nxt = sq5_r[I_S9];
      CLS_COLON: seg6_nxt = sq5_r[I_DOT];
      default:   seg6_nxt = '1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      seg6_r  <= seg6_nxt;
      rsq6_r  <= rsq5_r;
      side6_r <= side5_r;
    end
  end

  assign seg_sq  = seg6_r;
  assign ring_sq = rsq6_r;
  assign side    = side6_r;

endmodule

// File: rtl/dgc_root.sv
// Pipelined floor square root of the segment and ring squared distances.
module dgc_root import dgc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [SQ_W-1:0] a_sq,
  input  logic [SQ_W-1:0] b_sq,
  input  side_t           in_side,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [RT_W-1:0] a_rt,
  output logic [RT_W-1:0] b_rt,
  output side_t           out_side
);

  // two result bits per stage
  localparam int NST = RT_W / 2;

  typedef struct packed {
    logic [SQ_W-1:0] v;
    logic [SQ_W:0]   r;
  } rt_t;

  // One digit of the shift-subtract square root
  function automatic rt_t step(input rt_t s, input logic [SQ_W:0] b);
    rt_t         o;
    logic [SQ_W:0] trial;
    o     = s;
    trial = s.r + b;
    if ({1'b0, s.v} >= trial) begin
      o.v = SQ_W'({1'b0, s.v} - trial);
      o.r = (s.r >> 1) + b;
    end else begin
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  logic [NST-1:0] v_r;
  logic [NST-1:0] rdy;
  rt_t            a_in [NST];
  rt_t            b_in [NST];
  rt_t            a_r  [NST];
  rt_t            b_r  [NST];
  side_t          s_in [NST];
  side_t          s_r  [NST];

  // Stage handshake
  always_comb begin
    rdy[NST-1] = !v_r[NST-1] || !out_stall;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[0]) begin
        v_r[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  for (genvar g = 0; g < NST; g++) begin : g_stage
    localparam logic [SQ_W:0] BHi = (SQ_W+1)'(1) << (2 * (RT_W - 1 - 2 * g));
    localparam logic [SQ_W:0] BLo = (SQ_W+1)'(1) << (2 * (RT_W - 2 - 2 * g));
    if (g == 0) begin : g_first
      assign a_in[g] = '{v: a_sq, r: '0};
      assign b_in[g] = '{v: b_sq, r: '0};
      assign s_in[g] = in_side;
    end else begin : g_next
      assign a_in[g] = a_r[g-1];
      assign b_in[g] = b_r[g-1];
      assign s_in[g] = s_r[g-1];
    end
    // Advance two digits of both roots
    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        a_r[g] <= step(step(a_in[g], BHi), BLo);
        b_r[g] <= step(step(b_in[g], BHi), BLo);
        s_r[g] <= s_in[g];
      end
    end
  end

  assign a_rt     = a_r[NST-1].r[RT_W-1:0];
  assign b_rt     = b_r[NST-1].r[RT_W-1:0];
  assign out_side = s_r[NST-1];

endmodule

// File: rtl/dgc_shade.sv
// Output stage: stroke distance to coverage ramp, held in the output register.
module dgc_shade import dgc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [RT_W-1:0] seg_rt,
  input  logic [RT_W-1:0] ring_rt,
  input  side_t           side,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      coverage
);

  logic                    load;
  logic signed [DST_W:0]   rdiff;
  logic [DST_W-1:0]        ring_d, seg_d, near_d;
  logic [DST_W-1:0]        full, edge_lim;
  logic [DST_W-1:0]        gap;
  logic [9:0]              ramp;
  logic [7:0]              cov_nxt;
  logic                    valid_r;
  logic [7:0]              cov_r;

  assign load     = !valid_r || !out_stall;
  assign in_stall = !load;

  // Distance to the ring outline and the nearest stroke
  assign rdiff  = signed'({2'b00, ring_rt}) - signed'({{(DST_W+1-RAD_W){1'b0}}, side.rad});
  assign ring_d = rdiff[DST_W] ? DST_W'(-rdiff) : DST_W'(rdiff);
  assign seg_d  = {1'b0, seg_rt};

  always_comb begin
    near_d = DIST_FAR;
    if (side.hit_seg) begin
      near_d = seg_d;
    end
    if (side.hit_ring && ring_d < near_d) begin
      near_d = ring_d;
    end
  end

  // Map distance to alpha: solid core, four-step linear edge
  assign full     = side.colon ? FULL_COLON : FULL_DIGIT;
  assign edge_lim = side.colon ? EDGE_COLON : EDGE_DIGIT;
  assign gap      = edge_lim - near_d;
  assign ramp     = 10'(gap[1:0]) * 10'(COV_MAX);

  always_comb begin
    if (near_d <= full) begin
      cov_nxt = COV_MAX;
    end else if (near_d <= edge_lim) begin
      cov_nxt = ramp[9:2];
    end else begin
      cov_nxt = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cov_r <= cov_nxt;
    end
  end

  assign out_valid = valid_r;
  assign coverage  = cov_r;

endmodule

// File: rtl/digit_glyph_coverage_raster.sv
// Pipeline: the coverage of a request passes through 12 register stages
//   (6 geometry, 5 square root, 1 output).
// Throughput: one pixel per cycle while the output is not stalled; every stage
//   holds its own valid bit, so bubbles close up while the output is stalled.
// Reset: clears all valid bits and sets the colon cell width to 20.
// Top level of the digit glyph coverage raster.
module digit_glyph_coverage_raster import dgc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_code,
  input  logic [5:0] in_pixel_x,
  input  logic [6:0] in_pixel_y,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_coverage,
  input  logic       cfg_wr_en,
  input  logic [5:0] cfg_wr_data
);

  logic [5:0]      colon_w_r;
  logic            g_valid, g_stall;
  logic [SQ_W-1:0] g_seg_sq, g_ring_sq;
  side_t           g_side;
  logic            r_valid, r_stall;
  logic [RT_W-1:0] r_seg_rt, r_ring_rt;
  side_t           r_side;

  // Hold the colon cell width
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colon_w_r <= COLON_W_RESET;
    end else if (cfg_wr_en) begin
      colon_w_r <= cfg_wr_data;
    end
  end

  dgc_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .code      (in_char_code),
    .pix_x     (in_pixel_x),
    .pix_y     (in_pixel_y),
    .colon_w   (colon_w_r),
    .out_valid (g_valid),
    .out_stall (g_stall),
    .seg_sq    (g_seg_sq),
    .ring_sq   (g_ring_sq),
    .side      (g_side)
  );

  dgc_root u_root (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (g_valid),
    .in_stall  (g_stall),
    .a_sq      (g_seg_sq),
    .b_sq      (g_ring_sq),
    .in_side   (g_side),
    .out_valid (r_valid),
    .out_stall (r_stall),
    .a_rt      (r_seg_rt),
    .b_rt      (r_ring_rt),
    .out_side  (r_side)
  );

  dgc_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (r_valid),
    .in_stall  (r_stall),
    .seg_rt    (r_seg_rt),
    .ring_rt   (r_ring_rt),
    .side      (r_side),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .coverage  (out_coverage)
  );

`ifndef NO_ASSERTIONS
  // Input back-pressure only arises from a full pipe behind a stalled output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  // Reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A request with no stroke selected yields zero coverage
  a_blank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (r_valid && !r_stall && !r_side.hit_seg && !r_side.hit_ring) |=>
      (out_coverage == 8'd0))
    else $error("blank glyph gave nonzero coverage");
`endif

endmodule
